FILE: rtl/box_vs_line_table_collision_core_defines.svh
// ----------------------------------------------------------------------------
// box vs line table collision core - assertion macros
// wraps concurrent assertions so they can be compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef BOX_VS_LINE_TABLE_COLLISION_CORE_DEFINES_SVH
`define BOX_VS_LINE_TABLE_COLLISION_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked on every clock edge while rst is low
`define BVL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every clock edge, reset included
`define BVL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BVL_ASSERT(lbl, prop, msg)
`define BVL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/bvl_pkg.sv
// ----------------------------------------------------------------------------
// bvl_pkg
// shared types, request codes and helpers of the box vs line collision core
// ----------------------------------------------------------------------------
package bvl_pkg;

  localparam int MAX_LINES_DEF = 64;

  localparam int S_TDATA_W = 104;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 40;

  // request codes carried in the input word's tuser
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // -1.0 in q8.8
  localparam logic signed [15:0] VEL_NEG_ONE = -16'sd256;

  // one stored line collider, 51 bits
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] len;
    logic               along_x;
    logic               blk_before;
    logic               blk_after;
  } line_t;

  localparam int LINE_W = $bits(line_t);

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/bvl_ram.sv
// ----------------------------------------------------------------------------
// bvl_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bvl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/box_vs_line_table_collision_core.sv
// ----------------------------------------------------------------------------
// box_vs_line_table_collision_core
// table of axis-aligned one-way line colliders with a box collision query
// ----------------------------------------------------------------------------
// The core holds up to MAX_LINES line colliders in a ram, in append order.
// Each input word is a request selected by s_tuser: clear empties the table,
// append stores one line (or reports table_full when the table is already
// full), query scans the stored lines in order and returns the snapped box
// position for the first line that the box strictly straddles while moving
// in a direction the line blocks. Every request gives exactly one output
// word. Clear and append go straight to the done state; a query scans the
// table first and stops early on a hit. A finished word then waits in the
// done state until the output register is free to take it. The scan is
// paced by the single probe unit, which checks one stored line per cycle
// behind the ram's registered read port. The input is not ready while a
// request is in work, but a new request is taken while a finished output
// word still waits on m_tready. The table needs no clearing pass: only
// entries below the fill count are ever read.
`include "box_vs_line_table_collision_core_defines.svh"

module box_vs_line_table_collision_core
  import bvl_pkg::*;
#(
  parameter int MAX_LINES = MAX_LINES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // input words
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [15:0] coord_x, [31:16] coord_y, [47:32] extent, [62:48] box_height,
  // [78:63] vel_x, [94:79] vel_y, [95] runs_along_x,
  // [96] blocks_from_before, [97] blocks_from_after, [103:98] zero
  input  logic [S_TDATA_W-1:0] s_tdata,
  // [1:0] req_type
  input  logic [S_TUSER_W-1:0] s_tuser,
  // output words
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [0] hit, [16:1] snap_x, [32:17] snap_y, [33] table_full, [39:34] zero
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int AW = $clog2(MAX_LINES);
  localparam int CW = $clog2(MAX_LINES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_LINES);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] count;       // lines in the table
  logic [CW-1:0] idx;         // next entry to read during a scan
  logic          pend;        // read data of entry idx-1 is valid

  // query box, held for the scan
  logic signed [15:0] q_left;
  logic signed [15:0] q_top;
  logic signed [15:0] q_w;
  logic        [14:0] q_h;
  logic signed [15:0] q_vx;
  logic signed [15:0] q_vy;

  // result waiting for the output register
  logic               res_hit;
  logic signed [15:0] res_sx;
  logic signed [15:0] res_sy;
  logic               res_full;

  logic       s_acc;
  logic [1:0] req;
  logic       full;
  logic       ram_we;
  logic       ram_re;
  line_t      wr_line;
  line_t      rd_line;
  logic       slot_free;

  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign req       = s_tuser[1:0];
  assign full      = (count == FULL_COUNT);
  assign slot_free = !m_tvalid || m_tready;

  // line being appended, straight from the input word
  assign wr_line.x          = s_tdata[15:0];
  assign wr_line.y          = s_tdata[31:16];
  assign wr_line.len        = s_tdata[47:32];
  assign wr_line.along_x    = s_tdata[95];
  assign wr_line.blk_before = s_tdata[96];
  assign wr_line.blk_after  = s_tdata[97];

  assign ram_we = s_acc && (req == REQ_APPEND) && !full;
  assign ram_re = (state == ST_SCAN) && (idx < count);

  bvl_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_LINES)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (wr_line),
    .re    (ram_re),
    .raddr (idx[AW-1:0]),
    .rdata (rd_line)
  );

  // ---------------------------------------------------------------------
  // probe unit: tests one stored line against the query box per cycle
  // ---------------------------------------------------------------------
  logic signed [17:0] lx, ly, x_end, y_end;
  logic signed [17:0] box_l, box_t, box_r, box_b;
  logic               in_h, in_v;
  logic               probe_hit;
  logic signed [17:0] sx_raw, sy_raw;

  always_comb begin
    lx    = 18'(rd_line.x);
    ly    = 18'(rd_line.y);
    x_end = lx + 18'(rd_line.len);
    y_end = ly + 18'(rd_line.len);
    box_l = 18'(q_left);
    box_t = 18'(q_top);
    box_r = box_l + 18'(q_w);
    box_b = box_t + signed'({3'b000, q_h});

    in_h = (box_t < ly) && (box_b > ly) && (box_r > lx) && (box_l < x_end);
    in_v = (box_l < lx) && (box_r > lx) && (box_b > ly) && (box_t < y_end);

    probe_hit = 1'b0;
    sx_raw    = box_l;
    sy_raw    = box_t;
    if (rd_line.along_x) begin
      if (in_h && rd_line.blk_before && (q_vy > VEL_NEG_ONE)) begin
        // landing on top of the line
        probe_hit = 1'b1;
        sy_raw    = ly - signed'({3'b000, q_h});
      end else if (in_h && rd_line.blk_after && (q_vy < 16'sd0)) begin
        // bumping up from below
        probe_hit = 1'b1;
        sy_raw    = ly;
      end
    end else begin
      if (in_v && rd_line.blk_before && (q_vx > 16'sd0)) begin
        // moving right into the line
        probe_hit = 1'b1;
        sx_raw    = lx - 18'(q_w);
      end else if (in_v && rd_line.blk_after && (q_vx < 16'sd0)) begin
        // moving left into the line
        probe_hit = 1'b1;
        sx_raw    = lx;
      end
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      idx      <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // output register: load a finished word, else drop a taken one
      if ((state == ST_DONE) && slot_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            res_hit  <= 1'b0;
            res_sx   <= '0;
            res_sy   <= '0;
            res_full <= 1'b0;
            state    <= ST_DONE;
            case (req)
              REQ_CLEAR: begin
                count <= '0;
              end
              REQ_APPEND: begin
                if (full) begin
                  res_full <= 1'b1;
                end else begin
                  count <= count + 1'b1;
                end
              end
              REQ_QUERY: begin
                q_left <= s_tdata[15:0];
                q_top  <= s_tdata[31:16];
                q_w    <= s_tdata[47:32];
                q_h    <= s_tdata[62:48];
                q_vx   <= s_tdata[78:63];
                q_vy   <= s_tdata[94:79];
                idx    <= '0;
                pend   <= 1'b0;
                state  <= ST_SCAN;
              end
              default: begin
                // unknown request: no effect, zero result
              end
            endcase
          end
        end
        ST_SCAN: begin
          pend <= ram_re;
          if (ram_re) begin
            idx <= idx + 1'b1;
          end
          if (pend && probe_hit) begin
            res_hit <= 1'b1;
            res_sx  <= sat16(sx_raw);
            res_sy  <= sat16(sy_raw);
            state   <= ST_DONE;
          end else if (idx == count) begin
            // last entry checked without a hit, or empty table
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            m_tdata  <= {6'b000000, res_full, res_sy, res_sx, res_hit};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `BVL_ASSERT(a_append_grows, (!rst && s_acc && req == REQ_APPEND && !full) |=> (count == $past(count) + 1'b1), "append did not grow the table")
  `BVL_ASSERT(a_clear_empties, (!rst && s_acc && req == REQ_CLEAR) |=> (count == '0), "clear left lines in the table")
  `BVL_ASSERT(a_query_starts, (!rst && s_acc && req == REQ_QUERY) |=> (state == ST_SCAN && idx == '0 && !pend), "query scan did not start at entry zero")
  `BVL_ASSERT(a_scan_bound, (state == ST_SCAN) |-> (idx <= count), "scan ran past the fill count")
  `BVL_ASSERT_ALWAYS(a_hit_not_full, m_tvalid |-> !(m_tdata[0] && m_tdata[33]), "output word flags hit and table_full together")

endmodule

FILE: tb/sv/tb_collision_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// collision scoreboard
// own model of the line table, queue of predicted output words and checker
// ----------------------------------------------------------------------------
package tb_collision_scoreboard_pkg;
  import bvl_pkg::*;

  typedef struct {
    bit hit;
    int snap_x;
    int snap_y;
    bit table_full;
  } verdict_t;

  class collision_scoreboard;
    line_t       colliders[MAX_LINES_DEF];
    int unsigned fill;
    verdict_t    due[$];
    int          errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // strict straddle plus one-way direction test for one stored line
    function bit line_blocks(line_t ln, int left, int top, int w, int h,
                             int vx, int vy, output int ox, output int oy);
      int  lx;
      int  ly;
      int  ll;
      bit  straddle;
      lx = ln.x;
      ly = ln.y;
      ll = ln.len;
      ox = 0;
      oy = 0;
      if (ln.along_x) begin
        straddle = top < ly && top + h > ly && left + w > lx && left < lx + ll;
        if (ln.blk_before && vy > int'(VEL_NEG_ONE) && straddle) begin
          ox = left;
          oy = ly - h;
          return 1'b1;
        end
        if (ln.blk_after && vy < 0 && straddle) begin
          ox = left;
          oy = ly;
          return 1'b1;
        end
      end else begin
        straddle = left < lx && left + w > lx && top + h > ly && top < ly + ll;
        if (ln.blk_before && vx > 0 && straddle) begin
          ox = lx - w;
          oy = top;
          return 1'b1;
        end
        if (ln.blk_after && vx < 0 && straddle) begin
          ox = lx;
          oy = top;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // accepted request: update the table and queue the predicted word
    function void note_request(logic [S_TUSER_W-1:0] kind, logic [S_TDATA_W-1:0] w);
      verdict_t r;
      line_t    ln;
      int       cx;
      int       cy;
      int       ext;
      int       bh;
      int       vx;
      int       vy;
      int       ox;
      int       oy;
      r  = '{default: 0};
      cx = $signed(w[15:0]);
      cy = $signed(w[31:16]);
      ext = $signed(w[47:32]);
      bh = w[62:48];
      vx = $signed(w[78:63]);
      vy = $signed(w[94:79]);
      case (kind)
        REQ_CLEAR: begin
          fill = 0;
        end
        REQ_APPEND: begin
          if (fill >= MAX_LINES_DEF) begin
            r.table_full = 1'b1;
          end else begin
            ln.x          = w[15:0];
            ln.y          = w[31:16];
            ln.len        = w[47:32];
            ln.along_x    = w[95];
            ln.blk_before = w[96];
            ln.blk_after  = w[97];
            colliders[fill] = ln;
            fill++;
          end
        end
        REQ_QUERY: begin
          for (int i = 0; i < int'(fill); i++) begin
            if (line_blocks(colliders[i], cx, cy, ext, bh, vx, vy, ox, oy)) begin
              r.hit    = 1'b1;
              r.snap_x = clamp16(ox);
              r.snap_y = clamp16(oy);
              break;
            end
          end
        end
        default: ;
      endcase
      due.insert(due.size(), r);
    endfunction

    function void check_word(logic [M_TDATA_W-1:0] word);
      verdict_t e;
      int       sx;
      int       sy;
      if (due.size() == 0) begin
        $error("output word 0x%h with no request outstanding", word);
        errors++;
        return;
      end
      e  = due.pop_front();
      sx = $signed(word[16:1]);
      sy = $signed(word[32:17]);
      if (word[0] !== e.hit) begin
        $error("hit: expected %0d, actual %0d", e.hit, word[0]);
        errors++;
      end
      if (sx != e.snap_x || $isunknown(word[16:1])) begin
        $error("snap_x: expected %0d, actual %0d", e.snap_x, sx);
        errors++;
      end
      if (sy != e.snap_y || $isunknown(word[32:17])) begin
        $error("snap_y: expected %0d, actual %0d", e.snap_y, sy);
        errors++;
      end
      if (word[33] !== e.table_full) begin
        $error("table_full: expected %0d, actual %0d", e.table_full, word[33]);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_box_vs_line_table_collision_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_vs_line_table_collision_core
// self-checking bench for the line collider table with box query
// ----------------------------------------------------------------------------
// A short directed run covers both orientations, both blocking sides, the
// -1.0 velocity threshold, degenerate lengths and widths, saturated snaps
// and the unused request code. Random scenes follow: clear, a handful of
// lines around one spot, then boxes aimed at those lines so that most
// queries straddle something. A few scenes overfill the table. Loose random
// words are mixed in. Both handshakes idle at random, with one long stretch
// where neither side idles.
// ----------------------------------------------------------------------------
module tb_box_vs_line_table_collision_core;
  import bvl_pkg::*;
  import tb_collision_scoreboard_pkg::*;

  localparam int ITEM_TARGET = 1800;
  // request code with no meaning to the core
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = REQ_CLEAR;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  collision_scoreboard sb = new();
  int  items_sent = 0;
  // no idling on either side while set
  bit  steady = 1'b0;

  box_vs_line_table_collision_core #(
    .MAX_LINES(MAX_LINES_DEF)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // output side: ready changes on the falling edge, words taken on the rising
  always @(negedge clk) begin
    m_tready = steady || ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_word(m_tdata);
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  function automatic int pick(int lo, int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // drive one request word and hold it until the core takes it
  task automatic send_req(input logic [1:0] kind, input int cx, input int cy,
                          input int ext, input int bh, input int vx, input int vy,
                          input bit ax, input bit bb, input bit ba);
    logic [S_TDATA_W-1:0] w;
    if (!steady && $urandom_range(99) < 22) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    w        = '0;
    w[15:0]  = cx[15:0];
    w[31:16] = cy[15:0];
    w[47:32] = ext[15:0];
    w[62:48] = bh[14:0];
    w[78:63] = vx[15:0];
    w[94:79] = vy[15:0];
    w[95]    = ax;
    w[96]    = bb;
    w[97]    = ba;
    s_tdata  = w;
    s_tuser  = kind;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_request(kind, w);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    // empty table gives no hit
    send_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_req(REQ_QUERY, 10, 10, 20, 20, 0, 0, 0, 0, 0);
    // horizontal line blocking both sides, velocity around -1.0
    send_req(REQ_APPEND, 0, 100, 50, 0, 0, 0, 1, 1, 1);
    send_req(REQ_QUERY, 10, 90, 20, 20, 0, -256, 0, 0, 0);
    send_req(REQ_QUERY, 10, 90, 20, 20, 0, -255, 0, 0, 0);
    send_req(REQ_QUERY, 10, 90, 20, 20, 0, 0, 0, 0, 0);
    send_req(REQ_QUERY, 10, 90, 20, 20, 0, 32767, 0, 0, 0);
    // vertical lines, one per blocking side
    send_req(REQ_APPEND, 200, 0, 100, 0, 0, 0, 0, 1, 0);
    send_req(REQ_QUERY, 190, 10, 20, 20, 1, 0, 0, 0, 0);
    send_req(REQ_QUERY, 190, 10, 20, 20, -1, 0, 0, 0, 0);
    send_req(REQ_QUERY, 190, 10, 20, 20, 0, 0, 0, 0, 0);
    send_req(REQ_APPEND, 200, 0, 100, 0, 0, 0, 0, 0, 1);
    send_req(REQ_QUERY, 190, 10, 20, 20, -1, 0, 0, 0, 0);
    send_req(REQ_QUERY, 190, 10, 20, 20, -32768, 0, 0, 0, 0);
    // negative line length and negative box width never straddle
    send_req(REQ_APPEND, 500, 500, -20, 0, 0, 0, 1, 1, 1);
    send_req(REQ_QUERY, 490, 490, 20, 20, 0, 0, 0, 0, 0);
    send_req(REQ_QUERY, 190, 10, -5, 20, 1, 0, 0, 0, 0);
    // snaps below the 16-bit range saturate
    send_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_req(REQ_APPEND, -32768, -32700, 32767, 0, 0, 0, 1, 1, 0);
    send_req(REQ_QUERY, -32768, -32768, 100, 32767, 0, 0, 0, 0, 0);
    send_req(REQ_APPEND, -32000, -32768, 32767, 0, 0, 0, 0, 1, 0);
    send_req(REQ_QUERY, -32767, -100, 32767, 10, 256, 0, 0, 0, 0);
    // field extremes
    send_req(REQ_QUERY, 32767, 32767, 32767, 32767, 32767, 32767, 1, 1, 1);
    send_req(REQ_QUERY, -32768, -32768, -32768, 0, -32768, -32768, 0, 0, 0);
    // unused request code leaves the table alone
    send_req(REQ_UNUSED, -1, -1, -1, 32767, -1, -1, 1, 1, 1);
    send_req(REQ_QUERY, -32768, -32768, 100, 32767, 0, 0, 0, 0, 0);
  endtask

  // one loose word with fully random fields
  task automatic run_noise_item();
    int          r;
    logic [1:0]  kind;
    r = pick(0, 19);
    if (r < 10) kind = REQ_QUERY;
    else if (r < 17) kind = REQ_APPEND;
    else if (r < 19) kind = REQ_CLEAR;
    else kind = REQ_UNUSED;
    send_req(kind, pick(-32768, 32767), pick(-32768, 32767), pick(-32768, 32767),
             pick(0, 32767), pick(-32768, 32767), pick(-32768, 32767),
             pick(0, 1), pick(0, 1), pick(0, 1));
  endtask

  // clear, lay down lines around one spot, then aim boxes at them
  task automatic run_scene(input bit fill_up);
    int lx[MAX_LINES_DEF];
    int ly[MAX_LINES_DEF];
    int ll[MAX_LINES_DEF];
    bit la[MAX_LINES_DEF];
    int n;
    int stored;
    int bx;
    int by;
    int k;
    int w;
    int h;
    int left;
    int top;
    int vx;
    int vy;
    int nq;
    bit ax;
    send_req(REQ_CLEAR, pick(-32768, 32767), 0, 0, 0, 0, 0, 0, 0, 0);
    // most scenes sit mid-field, some against the coordinate limits
    if (pick(0, 99) < 15) begin
      bx = pick(0, 1) ? pick(-32768, -32500) : pick(32500, 32767);
      by = pick(0, 1) ? pick(-32768, -32500) : pick(32500, 32767);
    end else begin
      bx = pick(-2000, 2000);
      by = pick(-2000, 2000);
    end
    n = fill_up ? MAX_LINES_DEF + pick(1, 3) : pick(1, 8);
    stored = 0;
    for (int i = 0; i < n; i++) begin
      k  = (stored < MAX_LINES_DEF) ? stored : MAX_LINES_DEF - 1;
      ax = pick(0, 1);
      lx[k] = clip16(bx + pick(-300, 300));
      ly[k] = clip16(by + pick(-300, 300));
      ll[k] = (pick(0, 9) == 0) ? pick(-50, 0) : pick(1, 200);
      la[k] = ax;
      send_req(REQ_APPEND, lx[k], ly[k], ll[k], pick(0, 32767), pick(-32768, 32767),
               pick(-32768, 32767), ax, pick(0, 9) < 7, pick(0, 9) < 7);
      if (stored < MAX_LINES_DEF) stored++;
    end
    // on a full table a query with no hit scans all entries, so keep those short
    nq = fill_up ? 3 : pick(3, 10);
    for (int q = 0; q < nq; q++) begin
      w = pick(2, 60);
      h = (pick(0, 9) == 0) ? pick(2, 32767) : pick(2, 60);
      if (pick(0, 99) < 80) begin
        k = pick(0, stored - 1);
        if (la[k]) begin
          top  = ly[k] - pick(1, h - 1);
          left = lx[k] + pick(-w + 1, ll[k] - 1);
        end else begin
          left = lx[k] - pick(1, w - 1);
          top  = ly[k] + pick(-h + 1, ll[k] - 1);
        end
        // nudge onto or just past the edges now and then
        if (pick(0, 6) == 0) begin
          left += pick(-2, 2);
          top  += pick(-2, 2);
        end
      end else begin
        left = bx + pick(-400, 400);
        top  = by + pick(-400, 400);
      end
      vx = pick(-600, 600);
      vy = pick(-600, 600);
      if (pick(0, 4) == 0) begin
        vx = pick(-32768, 32767);
        vy = pick(-32768, 32767);
      end
      if (pick(0, 5) == 0) vy = pick(-257, -255);
      if (pick(0, 7) == 0) vx = pick(-1, 1);
      send_req(REQ_QUERY, clip16(left), clip16(top), w, h, vx, vy,
               pick(0, 1), pick(0, 1), pick(0, 1));
    end
  endtask

  initial begin
    int scene_no;
    scene_no = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    // sender holds off until the core has answered everything
    drain();

    while (items_sent < ITEM_TARGET) begin
      // long stretch where neither side idles
      steady = (items_sent >= 700 && items_sent < 1000);
      if (pick(0, 99) < 25) begin
        run_noise_item();
      end else begin
        run_scene(scene_no % 25 == 3);
        scene_no++;
        if (scene_no % 10 == 0) drain();
      end
    end
    steady = 1'b0;
    s_tvalid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    // room for any stray word after the last expected one
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
